### hdl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// shared constants for the floyd cycle length block
// ----------------------------------------------------------------------------
package fcl_pkg;
  // which runner update a finished map evaluation belongs to
  typedef enum logic [2:0] {
    PH_P1_SLOW,
    PH_P1_FAST1,
    PH_P1_FAST2,
    PH_P2_SLOW,
    PH_P2_FAST,
    PH_P3_FAST
  } phase_e;
endpackage

### hdl/fcl_mulmod.sv
// ----------------------------------------------------------------------------
// fcl_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module fcl_mulmod import fcl_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] x_i,     // serial operand, any value
  input  logic [WORD_BITS-1:0] y_i,     // parallel operand, below n
  input  logic [WORD_BITS-1:0] n_i,     // modulus, nonzero
  output logic                 done_o,
  output logic [WORD_BITS-1:0] r_o
);
  localparam int CntW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] x_q, x_d, y_q, y_d, n_q, n_d, r_q, r_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [WORD_BITS:0]   dbl, dbl_red, sum;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum     = dbl_red + (x_q[WORD_BITS-1] ? {1'b0, y_q} : '0);
    if (sum >= {1'b0, n_q}) sum = sum - {1'b0, n_q};
    x_d = x_q; y_d = y_q; n_d = n_q; r_d = r_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = x_i; y_d = y_i; n_d = n_i; r_d = '0;
      cnt_d = CntW'(WORD_BITS); busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = sum[WORD_BITS-1:0];
      x_d   = {x_q[WORD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; n_q <= n_d; r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;
endmodule

### hdl/floyd_cycle_length_quadratic_map.sv
// ----------------------------------------------------------------------------
// floyd_cycle_length_quadratic_map
// tortoise-hare cycle length of x -> ((x*x mod n)*a + b) mod n from seed 0
// ----------------------------------------------------------------------------
// Each input transfer carries n, a and b; the block returns n minus the length
// of the cycle that the map reaches from zero. One item is worked at a time.
// Every map step is two bit-serial modular products plus an offset add. An item
// first reduces a and b with the same multiplier, then takes roughly three
// steps per element of tail plus cycle, data dependent. A zero modulus returns
// zero at once. The result sits in an output register, so a new item may be
// taken while the previous result waits.
module floyd_cycle_length_quadratic_map import fcl_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [3*WORD_BITS-1:0] s_axis_tdata_i, // modulus, multiplier, offset
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [WORD_BITS-1:0] m_axis_tdata_o    // survivors
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RED_A = 3'd1, S_RED_B = 3'd2,
                         S_MUL1 = 3'd3, S_MUL2 = 3'd4, S_ADDB = 3'd5,
                         S_DONE = 3'd6;
  localparam int W = WORD_BITS;

  logic [2:0]   state_q, state_d;
  phase_e       ph_q, ph_d;
  logic         go_q, go_d;
  logic [W-1:0] n_q, n_d, a_q, a_d, b_q, b_d, mx_q, mx_d, v_q, v_d;
  logic [W-1:0] slow_q, slow_d, fast_q, fast_d, len_q, len_d, res_q, res_d;
  logic         ov_q, ov_d;
  logic [W-1:0] mm_x, mm_y, mm_r, y;
  logic         mm_done;
  logic [W:0]   addsum;

  // operand selection for the shared serial multiplier
  always_comb begin
    unique case (state_q)
      S_RED_A: begin mm_x = a_q; mm_y = W'(n_q != W'(1)); end
      S_RED_B: begin mm_x = b_q; mm_y = W'(n_q != W'(1)); end
      S_MUL1:  begin mm_x = mx_q; mm_y = mx_q; end
      default: begin mm_x = v_q; mm_y = a_q; end
    endcase
  end

  fcl_mulmod #(.WORD_BITS(W)) u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(go_q), .x_i(mm_x), .y_i(mm_y),
    .n_i(n_q), .done_o(mm_done), .r_o(mm_r)
  );

  // final offset add of a map step
  always_comb begin
    addsum = {1'b0, v_q} + {1'b0, b_q};
    if (addsum >= {1'b0, n_q}) addsum = addsum - {1'b0, n_q};
    y = addsum[W-1:0];
  end

  always_comb begin
    state_d = state_q; ph_d = ph_q; go_d = 1'b0;
    n_d = n_q; a_d = a_q; b_d = b_q; mx_d = mx_q; v_d = v_q;
    slow_d = slow_q; fast_d = fast_q; len_d = len_q; res_d = res_q;
    ov_d = ov_q;
    if (ov_q && m_axis_tready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          n_d = s_axis_tdata_i[W-1:0];
          a_d = s_axis_tdata_i[2*W-1:W];
          b_d = s_axis_tdata_i[3*W-1:2*W];
          if (s_axis_tdata_i[W-1:0] == '0) begin
            // n is zero here, so n - len gives zero
            len_d = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_RED_A;
            go_d = 1'b1;
          end
        end
      end
      S_RED_A: if (mm_done) begin
        a_d = mm_r; state_d = S_RED_B; go_d = 1'b1;
      end
      S_RED_B: if (mm_done) begin
        // first step: slow = f(0)
        b_d = mm_r; slow_d = '0; fast_d = '0; mx_d = '0;
        ph_d = PH_P1_SLOW; state_d = S_MUL1; go_d = 1'b1;
      end
      S_MUL1: if (mm_done) begin
        v_d = mm_r; state_d = S_MUL2; go_d = 1'b1;
      end
      S_MUL2: if (mm_done) begin
        v_d = mm_r; state_d = S_ADDB;
      end
      S_ADDB: begin
        state_d = S_MUL1; go_d = 1'b1;
        unique case (ph_q)
          PH_P1_SLOW:  begin slow_d = y; mx_d = fast_q; ph_d = PH_P1_FAST1; end
          PH_P1_FAST1: begin fast_d = y; mx_d = y; ph_d = PH_P1_FAST2; end
          PH_P1_FAST2: begin
            fast_d = y; mx_d = slow_q;
            if (y == slow_q) begin
              fast_d = '0; ph_d = PH_P2_SLOW;
            end else begin
              ph_d = PH_P1_SLOW;
            end
          end
          PH_P2_SLOW:  begin slow_d = y; mx_d = fast_q; ph_d = PH_P2_FAST; end
          PH_P2_FAST:  begin
            fast_d = y;
            if (y == slow_q) begin
              len_d = '0; mx_d = y; ph_d = PH_P3_FAST;
            end else begin
              mx_d = slow_q; ph_d = PH_P2_SLOW;
            end
          end
          default: begin
            // counting the cycle
            fast_d = y; len_d = len_q + 1'b1; mx_d = y;
            if (y == slow_q) begin
              state_d = S_DONE; go_d = 1'b0;
            end
          end
        endcase
      end
      default: begin
        // load the output register only once it is free
        if (!ov_q || m_axis_tready_i) begin
          res_d = n_q - len_q;
          ov_d = 1'b1; state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_P1_SLOW;
      go_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      go_q    <= go_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; a_q <= a_d; b_q <= b_d; mx_q <= mx_d; v_q <= v_d;
    slow_q <= slow_d; fast_q <= fast_d; len_q <= len_d; res_q <= res_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = res_q;
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the floyd cycle length block
// ----------------------------------------------------------------------------
// Items of (modulus, multiplier, offset) go in on the slave stream. Each
// accepted transfer runs a tortoise-hare walk in a local predictor, and the
// survivors value it expects is queued. Results on the master stream are
// checked in order. The run covers directed corner items first, then random
// items under four idling phases. Most moduli are small to keep the walks
// short; wide moduli use maps that settle at once.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int WORD_BITS = 32;
  localparam int CYC_PER_STEP = 2 * WORD_BITS + 16;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [3*WORD_BITS-1:0] s_axis_tdata_i;  // modulus, multiplier, offset
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [WORD_BITS-1:0]   m_axis_tdata_o;  // survivors

  floyd_cycle_length_quadratic_map #(.WORD_BITS(WORD_BITS)) dut (.*);

  // one map evaluation, products formed exactly in 64 bits
  function automatic longint unsigned quad_map(longint unsigned x, longint unsigned n,
                                               longint unsigned a, longint unsigned b);
    longint unsigned v;
    v = (x * x) % n;
    v = (v * a) % n;
    return (v + b) % n;
  endfunction

  class survivors_board;
    logic [WORD_BITS-1:0] pending_q[$];
    int errors;
    longint unsigned work_cycles;

    // tortoise-hare walk; also tallies map steps for the cycle budget
    function void note_item(logic [WORD_BITS-1:0] n, logic [WORD_BITS-1:0] a,
                            logic [WORD_BITS-1:0] b);
      longint unsigned tort, hare, len, steps;
      tort = 0;
      hare = 0;
      len = 0;
      steps = 0;
      if (n == 0) begin
        pending_q.push_back('0);
        work_cycles += 100;
        return;
      end
      do begin
        tort = quad_map(tort, n, a, b);
        hare = quad_map(quad_map(hare, n, a, b), n, a, b);
        steps += 3;
      end while (tort != hare);
      hare = 0;
      do begin
        tort = quad_map(tort, n, a, b);
        hare = quad_map(hare, n, a, b);
        steps += 2;
      end while (tort != hare);
      do begin
        hare = quad_map(hare, n, a, b);
        len++;
        steps++;
      end while (tort != hare);
      pending_q.push_back(WORD_BITS'(longint'(n) - len));
      work_cycles += steps * CYC_PER_STEP + 4 * WORD_BITS + 200;
    endfunction

    function void check_result(logic [WORD_BITS-1:0] got);
      logic [WORD_BITS-1:0] want;
      if (pending_q.size() == 0) begin
        $error("survivors: result 0x%08h with nothing expected", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $error("survivors: expected 0x%08h, actual 0x%08h", want, got);
        errors++;
      end
    endfunction
  endclass

  survivors_board board;
  int send_idle_pct;
  int recv_stall_pct;
  longint unsigned cycle_cnt;

  // clock, 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // result check on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
  end

  // watchdog, generous multiple of the slowest expected run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 4 * board.work_cycles + 200000) begin
      $display("[floyd_cycle_length_quadratic_map] ERROR");
      $finish;
    end
  end

  // one transfer on the slave side, with an optional idle gap first
  task automatic send_item(logic [WORD_BITS-1:0] n, logic [WORD_BITS-1:0] a,
                           logic [WORD_BITS-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = {$urandom, $urandom, $urandom};
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {b, a, n};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_item(n, a, b);
    @(negedge clk_i);
  endtask

  // mostly small moduli; wide ones only with maps that settle quickly
  task automatic send_random;
    logic [WORD_BITS-1:0] n, a, b;
    int pick;
    pick = $urandom_range(9);
    a = $urandom;
    b = $urandom;
    if (pick < 7) begin
      n = $urandom_range(1024, 1);
    end else if (pick == 7) begin
      n = $urandom;
      a = '0;
    end else if (pick == 8) begin
      n = $urandom;
      b = '0;
    end else begin
      n = $urandom_range(64, 0);
    end
    send_item(n, a, b);
  endtask

  initial begin
    board = new();
    board.errors = 0;
    board.work_cycles = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners: zero modulus, modulus one, widest fields
    send_item('0, '0, '0);
    send_item('0, '1, '1);
    send_item(32'd1, '0, '0);
    send_item(32'd1, '1, '1);
    send_item('1, '0, '1);
    send_item('1, '0, '0);
    send_item('1, 32'd1, '0);
    send_item('1, '1, '0);
    send_item(32'h8000_0000, '0, 32'h7fff_ffff);
    send_item(32'd2, '1, '1);
    send_item(32'd3, 32'd1, 32'd1);
    send_item(32'd7, 32'd2, 32'd3);
    send_item(32'd1000, 32'd1, 32'd1);
    send_item(32'd1024, '1, '1);
    send_item(32'd997, 32'h5555_5555, 32'haaaa_aaaa);
    send_item(32'd509, 32'd0, 32'd508);
    send_item(32'd256, 32'd1, 32'd0);

    // random items under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (25) send_random();
    end
    s_axis_tvalid_i = 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[floyd_cycle_length_quadratic_map] OK");
    end else begin
      $display("[floyd_cycle_length_quadratic_map] ERROR");
    end
    $finish;
  end
endmodule
